FILE: design/kef_pkg.sv
// Shared types and constants for the keypad encoder event FIFO.
// No dependencies; every other design file refers to this package by scoped names.
package kef_pkg;

    // Sizes of the key front end
    localparam int PUSH_KEYS   = 4;
    localparam int ROTARY_KEYS = 2;
    localparam int FIFO_DEPTH  = 16;

    // Item field widths
    localparam int OPCODE_W   = 2;
    localparam int TIME_W     = 16;
    localparam int PUSH_LVL_W = 4;
    localparam int ROT_LVL_W  = 2;
    localparam int STATUS_W   = 2;
    localparam int CODE_W     = 8;
    localparam int LEVEL_W    = 4;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_PERIOD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PUSH_BASE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROTARY_BASE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_ENABLED = 2'd3;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] SCAN_PERIOD_RST = 8'd6;
    localparam logic [CFG_DATA_W-1:0] PUSH_BASE_RST   = 8'd0;
    localparam logic [CFG_DATA_W-1:0] ROTARY_BASE_RST = 8'd8;

    // Derived widths
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int PUSH_IDX_W = (PUSH_KEYS > 1) ? $clog2(PUSH_KEYS) : 1;
    localparam int ROT_IDX_W  = (ROTARY_KEYS > 1) ? $clog2(ROTARY_KEYS) : 1;
    localparam int PUSH_PAD_W = (PUSH_KEYS > PUSH_LVL_W) ? PUSH_KEYS : PUSH_LVL_W;
    localparam int ROT_PAD_W  = (ROTARY_KEYS > ROT_LVL_W) ? ROTARY_KEYS : ROT_LVL_W;

    // Push key phases
    localparam logic [1:0] PP_IDLE     = 2'd0;
    localparam logic [1:0] PP_ARMED    = 2'd1;
    localparam logic [1:0] PP_WAIT_REL = 2'd2;

    // Rotary walk phases
    localparam logic [1:0] RP_IDLE  = 2'd0;
    localparam logic [1:0] RP_FIRST = 2'd1;
    localparam logic [1:0] RP_MID   = 2'd2;
    localparam logic [1:0] RP_LAST  = 2'd3;

    // Rotary pin patterns, A in bit 1 and B in bit 0
    localparam logic [1:0] PINS_NONE = 2'b00;
    localparam logic [1:0] PINS_B    = 2'b01;
    localparam logic [1:0] PINS_A    = 2'b10;
    localparam logic [1:0] PINS_BOTH = 2'b11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SCAN   = 2'd0,
        OP_ROTARY = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        RS_NONE     = 2'd0,
        RS_EMPTY    = 2'd1,
        RS_CODE     = 2'd2,
        RS_DISABLED = 2'd3
    } read_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ROT,
        ST_READ,
        ST_FINISH
    } state_t;

endpackage

FILE: design/kef_if.sv
// Handshake channels for input items and result items.
// Depends on kef_pkg for the field widths.
interface kef_in_if;
    logic                           valid;
    logic                           ready;
    logic [kef_pkg::OPCODE_W-1:0]   opcode;
    logic [kef_pkg::TIME_W-1:0]     now_time;
    logic [kef_pkg::PUSH_LVL_W-1:0] push_levels;
    logic [kef_pkg::ROT_LVL_W-1:0]  rotary_a_levels;
    logic [kef_pkg::ROT_LVL_W-1:0]  rotary_b_levels;

    modport source (
        output valid, opcode, now_time, push_levels, rotary_a_levels, rotary_b_levels,
        input  ready
    );
    modport sink (
        input  valid, opcode, now_time, push_levels, rotary_a_levels, rotary_b_levels,
        output ready
    );
endinterface

interface kef_out_if;
    logic                         valid;
    logic                         ready;
    logic [kef_pkg::STATUS_W-1:0] read_status;
    logic [kef_pkg::CODE_W-1:0]   key_code;
    logic [kef_pkg::LEVEL_W-1:0]  fifo_level;
    logic                         push_held;

    modport source (
        output valid, read_status, key_code, fifo_level, push_held,
        input  ready
    );
    modport sink (
        input  valid, read_status, key_code, fifo_level, push_held,
        output ready
    );
endinterface

FILE: design/keypad_encoder_event_fifo.sv
// Keypad encoder event FIFO: push-key scanner and quadrature decoder feeding a code FIFO.
// Each accepted item is worked on by a sequencer that steps one key per cycle: a scan
// walks the push keys, a pin change walks the rotary keys (skipped while a push key
// is held), and a read goes through the registered code store port. A new item is
// taken only in idle, after the last result is handed on, and may be taken while it waits.
// Reset (rst_n, asynchronous, active low) clears all control state; the code store has none.
module keypad_encoder_event_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kef_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [kef_pkg::CFG_DATA_W-1:0]    cfg_data,
    kef_in_if.sink                            in_item,
    kef_out_if.source                         out_item
);

    localparam int PTR_W      = kef_pkg::PTR_W;
    localparam int PUSH_IDX_W = kef_pkg::PUSH_IDX_W;
    localparam int ROT_IDX_W  = kef_pkg::ROT_IDX_W;

    // Configuration registers
    logic [kef_pkg::CFG_DATA_W-1:0] scan_period_reg;
    logic [kef_pkg::CFG_DATA_W-1:0] push_base_reg;
    logic [kef_pkg::CFG_DATA_W-1:0] rotary_base_reg;
    logic                           read_enabled_reg;

    // Sequencer and key state
    kef_pkg::state_t                state_reg, state_next;
    logic [PUSH_IDX_W-1:0]          key_idx_reg, key_idx_next;
    logic [ROT_IDX_W-1:0]           rot_idx_reg, rot_idx_next;
    logic [1:0]                     push_phase_reg [kef_pkg::PUSH_KEYS];
    logic [1:0]                     push_phase_next [kef_pkg::PUSH_KEYS];
    logic [kef_pkg::TIME_W-1:0]     deadline_reg [kef_pkg::PUSH_KEYS];
    logic [kef_pkg::TIME_W-1:0]     deadline_next [kef_pkg::PUSH_KEYS];
    logic                           busy_reg, busy_next;
    logic [1:0]                     rot_phase_reg [kef_pkg::ROTARY_KEYS];
    logic [1:0]                     rot_phase_next [kef_pkg::ROTARY_KEYS];
    logic [kef_pkg::CODE_W-1:0]     pending_reg, pending_next;
    logic [PTR_W-1:0]               wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]               rd_ptr_reg, rd_ptr_next;
    kef_pkg::read_status_t          status_reg, status_next;

    // Latched input item
    logic [kef_pkg::TIME_W-1:0]     now_reg;
    logic [kef_pkg::PUSH_PAD_W-1:0] push_lvl_reg;
    logic [kef_pkg::ROT_PAD_W-1:0]  rot_a_reg;
    logic [kef_pkg::ROT_PAD_W-1:0]  rot_b_reg;

    // Code store
    logic [kef_pkg::CODE_W-1:0]     code_store [kef_pkg::FIFO_DEPTH];
    logic [kef_pkg::CODE_W-1:0]     rd_data_reg;
    logic                           mem_we;
    logic [kef_pkg::CODE_W-1:0]     mem_wdata;
    logic                           mem_re;

    // Output register
    logic                           out_valid_reg;
    logic [kef_pkg::STATUS_W-1:0]   out_status_reg;
    logic [kef_pkg::CODE_W-1:0]     out_code_reg;
    logic [kef_pkg::LEVEL_W-1:0]    out_level_reg;
    logic                           out_held_reg;
    logic                           out_load;

    logic                           in_ready;
    logic                           in_accept;

    // FIFO pointer arithmetic
    logic [PTR_W-1:0]               wr_ptr_inc;
    logic [PTR_W-1:0]               rd_ptr_inc;
    logic                           fifo_full;
    logic [PTR_W-1:0]               fifo_count;

    // Current key operands
    logic                           key_pressed;
    logic [kef_pkg::CODE_W-1:0]     push_code;
    logic [1:0]                     rot_pins;
    logic [kef_pkg::CODE_W-1:0]     up_code;
    logic [kef_pkg::CODE_W-1:0]     down_code;

    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(kef_pkg::FIFO_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(kef_pkg::FIFO_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
    assign fifo_full  = (wr_ptr_inc == rd_ptr_reg);
    assign fifo_count = (wr_ptr_reg >= rd_ptr_reg) ? wr_ptr_reg - rd_ptr_reg
                      : PTR_W'(kef_pkg::FIFO_DEPTH) + wr_ptr_reg - rd_ptr_reg;

    assign key_pressed = push_lvl_reg[key_idx_reg];
    assign push_code   = push_base_reg + kef_pkg::CODE_W'(key_idx_reg);
    assign rot_pins    = {rot_a_reg[rot_idx_reg], rot_b_reg[rot_idx_reg]};
    assign up_code     = rotary_base_reg + kef_pkg::CODE_W'({rot_idx_reg, 1'b0});
    assign down_code   = up_code + 1'b1;

    assign in_accept   = in_ready && in_item.valid;
    assign in_item.ready = in_ready;

    assign out_item.valid       = out_valid_reg;
    assign out_item.read_status = out_status_reg;
    assign out_item.key_code    = out_code_reg;
    assign out_item.fifo_level  = out_level_reg;
    assign out_item.push_held   = out_held_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg  <= kef_pkg::SCAN_PERIOD_RST;
            push_base_reg    <= kef_pkg::PUSH_BASE_RST;
            rotary_base_reg  <= kef_pkg::ROTARY_BASE_RST;
            read_enabled_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kef_pkg::CFG_SCAN_PERIOD:  scan_period_reg  <= cfg_data;
                kef_pkg::CFG_PUSH_BASE:    push_base_reg    <= cfg_data;
                kef_pkg::CFG_ROTARY_BASE:  rotary_base_reg  <= cfg_data;
                kef_pkg::CFG_READ_ENABLED: read_enabled_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Sequencer state and key state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kef_pkg::ST_IDLE;
            key_idx_reg <= '0;
            rot_idx_reg <= '0;
            busy_reg    <= 1'b0;
            pending_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            status_reg  <= kef_pkg::RS_NONE;
            for (int i = 0; i < kef_pkg::PUSH_KEYS; i++)
            begin
                push_phase_reg[i] <= kef_pkg::PP_IDLE;
                deadline_reg[i]   <= '0;
            end
            for (int i = 0; i < kef_pkg::ROTARY_KEYS; i++)
            begin
                rot_phase_reg[i] <= kef_pkg::RP_IDLE;
            end
        end
        else
        begin
            state_reg      <= state_next;
            key_idx_reg    <= key_idx_next;
            rot_idx_reg    <= rot_idx_next;
            busy_reg       <= busy_next;
            pending_reg    <= pending_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            status_reg     <= status_next;
            push_phase_reg <= push_phase_next;
            deadline_reg   <= deadline_next;
            rot_phase_reg  <= rot_phase_next;
        end
    end

    // Input item capture
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_reg      <= in_item.now_time;
            push_lvl_reg <= kef_pkg::PUSH_PAD_W'(in_item.push_levels);
            rot_a_reg    <= kef_pkg::ROT_PAD_W'(in_item.rotary_a_levels);
            rot_b_reg    <= kef_pkg::ROT_PAD_W'(in_item.rotary_b_levels);
        end
    end

    // Code store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            code_store[wr_ptr_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= code_store[rd_ptr_reg];
        end
    end

    // Next state and datapath control: one key per cycle
    always_comb
    begin
        state_next      = state_reg;
        key_idx_next    = key_idx_reg;
        rot_idx_next    = rot_idx_reg;
        push_phase_next = push_phase_reg;
        deadline_next   = deadline_reg;
        busy_next       = busy_reg;
        rot_phase_next  = rot_phase_reg;
        pending_next    = pending_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_wdata       = pending_reg;
        mem_re          = 1'b0;
        out_load        = 1'b0;
        in_ready        = 1'b0;

        case (state_reg)
            kef_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_item.valid)
                begin
                    key_idx_next = '0;
                    rot_idx_next = '0;
                    status_next  = kef_pkg::RS_NONE;
                    case (kef_pkg::opcode_t'(in_item.opcode))
                        kef_pkg::OP_SCAN:   state_next = kef_pkg::ST_SCAN;
                        kef_pkg::OP_ROTARY: state_next = kef_pkg::ST_ROT;
                        kef_pkg::OP_READ:   state_next = kef_pkg::ST_READ;
                        default:            state_next = kef_pkg::ST_FINISH;
                    endcase
                end
            end

            // Step one push key
            kef_pkg::ST_SCAN:
            begin
                case (push_phase_reg[key_idx_reg])
                    kef_pkg::PP_IDLE:
                    begin
                        deadline_next[key_idx_reg] =
                            now_reg + kef_pkg::TIME_W'(scan_period_reg);
                        push_phase_next[key_idx_reg] = kef_pkg::PP_ARMED;
                    end
                    kef_pkg::PP_ARMED:
                    begin
                        if (deadline_reg[key_idx_reg] <= now_reg)
                        begin
                            if (key_pressed)
                            begin
                                busy_next = 1'b1;
                                push_phase_next[key_idx_reg] = kef_pkg::PP_WAIT_REL;
                                if (!fifo_full)
                                begin
                                    mem_we      = 1'b1;
                                    mem_wdata   = push_code;
                                    wr_ptr_next = wr_ptr_inc;
                                end
                            end
                            else
                            begin
                                push_phase_next[key_idx_reg] = kef_pkg::PP_IDLE;
                            end
                        end
                    end
                    kef_pkg::PP_WAIT_REL:
                    begin
                        if (!key_pressed)
                        begin
                            busy_next = 1'b0;
                            push_phase_next[key_idx_reg] = kef_pkg::PP_IDLE;
                        end
                    end
                    default: ;
                endcase
                if (key_idx_reg == PUSH_IDX_W'(kef_pkg::PUSH_KEYS - 1))
                begin
                    state_next = kef_pkg::ST_FINISH;
                end
                else
                begin
                    key_idx_next = key_idx_reg + 1'b1;
                end
            end

            // Step one rotary key's quadrature walk
            kef_pkg::ST_ROT:
            begin
                if (busy_reg)
                begin
                    state_next = kef_pkg::ST_FINISH;
                end
                else
                begin
                    case (rot_phase_reg[rot_idx_reg])
                        kef_pkg::RP_IDLE:
                        begin
                            if (rot_pins == kef_pkg::PINS_B)
                            begin
                                pending_next = down_code;
                                rot_phase_next[rot_idx_reg] = kef_pkg::RP_FIRST;
                            end
                            else if (rot_pins == kef_pkg::PINS_A)
                            begin
                                pending_next = up_code;
                                rot_phase_next[rot_idx_reg] = kef_pkg::RP_FIRST;
                            end
                        end
                        kef_pkg::RP_FIRST:
                        begin
                            rot_phase_next[rot_idx_reg] =
                                (rot_pins == kef_pkg::PINS_BOTH) ? kef_pkg::RP_MID
                                                                 : kef_pkg::RP_IDLE;
                        end
                        kef_pkg::RP_MID:
                        begin
                            if ((rot_pins == kef_pkg::PINS_B && pending_reg == up_code) ||
                                (rot_pins == kef_pkg::PINS_A && pending_reg == down_code))
                            begin
                                rot_phase_next[rot_idx_reg] = kef_pkg::RP_LAST;
                            end
                            else
                            begin
                                rot_phase_next[rot_idx_reg] = kef_pkg::RP_IDLE;
                            end
                        end
                        default:
                        begin
                            if (rot_pins == kef_pkg::PINS_NONE && !fifo_full)
                            begin
                                mem_we      = 1'b1;
                                mem_wdata   = pending_reg;
                                wr_ptr_next = wr_ptr_inc;
                            end
                            rot_phase_next[rot_idx_reg] = kef_pkg::RP_IDLE;
                        end
                    endcase
                    if (rot_idx_reg == ROT_IDX_W'(kef_pkg::ROTARY_KEYS - 1))
                    begin
                        state_next = kef_pkg::ST_FINISH;
                    end
                    else
                    begin
                        rot_idx_next = rot_idx_reg + 1'b1;
                    end
                end
            end

            // Pop one code through the registered read port
            kef_pkg::ST_READ:
            begin
                if (!read_enabled_reg)
                begin
                    status_next = kef_pkg::RS_DISABLED;
                end
                else if (fifo_count == '0)
                begin
                    status_next = kef_pkg::RS_EMPTY;
                end
                else
                begin
                    status_next = kef_pkg::RS_CODE;
                    mem_re      = 1'b1;
                    rd_ptr_next = rd_ptr_inc;
                end
                state_next = kef_pkg::ST_FINISH;
            end

            // Hand the result to the output register once it is free
            kef_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_item.ready)
                begin
                    out_load   = 1'b1;
                    state_next = kef_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = kef_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_item.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_code_reg   <= (status_reg == kef_pkg::RS_CODE) ? rd_data_reg : '0;
            out_level_reg  <= kef_pkg::LEVEL_W'(fifo_count);
            out_held_reg   <= busy_reg;
        end
    end

`ifndef SYNTHESIS
    // Pointers stay inside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg <= PTR_W'(kef_pkg::FIFO_DEPTH - 1)) &&
        (rd_ptr_reg <= PTR_W'(kef_pkg::FIFO_DEPTH - 1)))
    else $error("FIFO pointer out of range");

    // A store write never overruns the read pointer.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (wr_ptr_inc != rd_ptr_reg))
    else $error("code written to a full FIFO");

    // The read pointer only moves while a read item is worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != kef_pkg::ST_READ) |=> $stable(rd_ptr_reg))
    else $error("read pointer moved outside a read");

    // An accepted item always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != kef_pkg::ST_IDLE))
    else $error("accepted item was not started");

    // A new result is loaded only after the sequencer finished an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == kef_pkg::ST_FINISH))
    else $error("result shown without a finished item");
`endif

endmodule

FILE: dv/tb_keypad_encoder_event_fifo.sv
// Testbench for the keypad encoder event FIFO: a directed table, then random phases.
// Depends on kef_pkg, the kef_in_if / kef_out_if channels and the keypad_encoder_event_fifo RTL.
// Typed table rows are checked against their row; every other result against an in-bench model.
module tb_keypad_encoder_event_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    import kef_pkg::*;

    localparam int STALL_LIMIT    = 2000;
    localparam int PHASES         = 6;
    localparam int ITEMS_PER_PHASE = 217;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        opcode_t               op;
        logic [TIME_W-1:0]     now;
        logic [PUSH_LVL_W-1:0] push;
        logic [ROT_LVL_W-1:0]  a;
        logic [ROT_LVL_W-1:0]  b;
    } key_event_t;

    typedef struct packed {
        read_status_t       status;
        logic [CODE_W-1:0]  code;
        logic [LEVEL_W-1:0] level;
        logic               held;
    } key_result_t;

    typedef struct packed {
        key_event_t  ev;
        logic        typed;
        key_result_t res;
    } scan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    kef_in_if  in_ch ();
    kef_out_if out_ch ();

    keypad_encoder_event_fifo i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_ch),
        .out_item  (out_ch)
    );

    // Model state: configuration, code FIFO, push keys and rotary knobs.
    logic [7:0]          cfg_period;
    logic [7:0]          cfg_push_base;
    logic [7:0]          cfg_knob_base;
    logic                cfg_read_en;
    logic [CODE_W-1:0]   code_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_idx;
    logic [PTR_W-1:0]    rd_idx;
    logic [1:0]          key_phase [PUSH_KEYS];
    logic [TIME_W-1:0]   key_deadline [PUSH_KEYS];
    logic                key_busy;
    logic [1:0]          knob_phase [ROTARY_KEYS];
    logic [CODE_W-1:0]   knob_code;

    // Random stimulus state.
    logic [TIME_W-1:0]     gen_time;
    logic [PUSH_LVL_W-1:0] gen_levels;
    int                    knob_pos [ROTARY_KEYS];
    logic                  knob_down [ROTARY_KEYS];
    logic                  knob_active [ROTARY_KEYS];

    key_result_t expected_results [$];
    key_result_t arrived;
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Put a code into the modeled FIFO; a full FIFO drops it.
    function automatic void store_code(logic [CODE_W-1:0] code);
        if (PTR_W'(wr_idx + 1'b1) != rd_idx)
        begin
            code_mem[wr_idx] = code;
            wr_idx = wr_idx + 1'b1;
        end
    endfunction

    // Work out the result of one accepted item and advance the model.
    function automatic key_result_t predict_key_event(key_event_t ev);
        key_result_t       r;
        logic              pressed;
        logic [CODE_W-1:0] up_code;
        logic [CODE_W-1:0] down_code;
        logic [1:0]        pins;

        r.status = RS_NONE;
        r.code   = '0;
        case (ev.op)
            OP_SCAN:
            begin
                for (int i = 0; i < PUSH_KEYS; i++)
                begin
                    pressed = ev.push[i];
                    case (key_phase[i])
                        PP_IDLE:
                        begin
                            key_deadline[i] = ev.now + TIME_W'(cfg_period);
                            key_phase[i]    = PP_ARMED;
                        end
                        PP_ARMED:
                        begin
                            // Deadline compare is plain unsigned, so it wraps with time.
                            if (key_deadline[i] <= ev.now)
                            begin
                                if (pressed)
                                begin
                                    key_busy = 1'b1;
                                    store_code(CODE_W'(cfg_push_base + i));
                                    key_phase[i] = PP_WAIT_REL;
                                end
                                else
                                begin
                                    key_phase[i] = PP_IDLE;
                                end
                            end
                        end
                        PP_WAIT_REL:
                        begin
                            // Any release clears the one shared busy flag.
                            if (!pressed)
                            begin
                                key_busy     = 1'b0;
                                key_phase[i] = PP_IDLE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            OP_ROTARY:
            begin
                if (!key_busy)
                begin
                    for (int i = 0; i < ROTARY_KEYS; i++)
                    begin
                        up_code   = CODE_W'(cfg_knob_base + 2 * i);
                        down_code = up_code + 1'b1;
                        pins      = {ev.a[i], ev.b[i]};
                        case (knob_phase[i])
                            RP_IDLE:
                            begin
                                if (pins == PINS_B)
                                begin
                                    knob_code     = down_code;
                                    knob_phase[i] = RP_FIRST;
                                end
                                else if (pins == PINS_A)
                                begin
                                    knob_code     = up_code;
                                    knob_phase[i] = RP_FIRST;
                                end
                            end
                            RP_FIRST:
                            begin
                                knob_phase[i] = (pins == PINS_BOTH) ? RP_MID : RP_IDLE;
                            end
                            RP_MID:
                            begin
                                if ((pins == PINS_B && knob_code == up_code) ||
                                    (pins == PINS_A && knob_code == down_code))
                                    knob_phase[i] = RP_LAST;
                                else
                                    knob_phase[i] = RP_IDLE;
                            end
                            default:
                            begin
                                if (pins == PINS_NONE)
                                    store_code(knob_code);
                                knob_phase[i] = RP_IDLE;
                            end
                        endcase
                    end
                end
            end
            OP_READ:
            begin
                if (!cfg_read_en)
                begin
                    r.status = RS_DISABLED;
                end
                else if (wr_idx == rd_idx)
                begin
                    r.status = RS_EMPTY;
                end
                else
                begin
                    r.code   = code_mem[rd_idx];
                    rd_idx   = rd_idx + 1'b1;
                    r.status = RS_CODE;
                end
            end
            default:
            begin
            end
        endcase
        r.level = LEVEL_W'(wr_idx - rd_idx);
        r.held  = key_busy;
        return r;
    endfunction

    function automatic scan_row_t mk_row(opcode_t op, int now, int push, int a, int b,
                                         logic typed, read_status_t st, int code,
                                         int level, int held);
        scan_row_t row;

        row.ev.op      = op;
        row.ev.now     = TIME_W'(now);
        row.ev.push    = PUSH_LVL_W'(push);
        row.ev.a       = ROT_LVL_W'(a);
        row.ev.b       = ROT_LVL_W'(b);
        row.typed      = typed;
        row.res.status = st;
        row.res.code   = CODE_W'(code);
        row.res.level  = LEVEL_W'(level);
        row.res.held   = held[0];
        return row;
    endfunction

    // Pin pattern of a detent at step pos, A leading for up and B leading for down.
    function automatic logic [1:0] knob_pins(logic down, int pos);
        case (pos)
            0:       return down ? PINS_B : PINS_A;
            1:       return PINS_BOTH;
            2:       return down ? PINS_A : PINS_B;
            default: return PINS_NONE;
        endcase
    endfunction

    // Offer one item after a random gap, wait for it to be taken, and queue its result.
    task automatic send_event(key_event_t ev, logic typed, key_result_t typed_res);
        int          gap;
        key_result_t r;

        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 40)
            gap++;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.opcode          <= ev.op;
        in_ch.now_time        <= ev.now;
        in_ch.push_levels     <= ev.push;
        in_ch.rotary_a_levels <= ev.a;
        in_ch.rotary_b_levels <= ev.b;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        r = predict_key_event(ev);
        if (typed)
            r = typed_res;
        expected_results.push_back(r);
    endtask

    // Stop offering items and wait until every queued result has come back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_SCAN_PERIOD: cfg_period    = data;
            CFG_PUSH_BASE:   cfg_push_base = data;
            CFG_ROTARY_BASE: cfg_knob_base = data;
            default:         cfg_read_en   = data[0];
        endcase
    endtask

    task automatic apply_settings(logic [7:0] period, logic [7:0] push_base,
                                  logic [7:0] knob_base, logic read_en);
        write_reg(CFG_SCAN_PERIOD, period);
        write_reg(CFG_PUSH_BASE, push_base);
        write_reg(CFG_ROTARY_BASE, knob_base);
        write_reg(CFG_READ_ENABLED, {7'd0, read_en});
        cfg_we <= 1'b0;
    endtask

    // Random item: mostly advancing scans and clean detents, some reads, noise and unused opcodes.
    task automatic next_random_event(input int read_w, output key_event_t ev);
        int         pick;
        logic [1:0] pins;

        pick    = $urandom_range(0, 99);
        ev.op   = OP_READ;
        ev.now  = TIME_W'($urandom);
        ev.push = PUSH_LVL_W'($urandom);
        ev.a    = ROT_LVL_W'($urandom);
        ev.b    = ROT_LVL_W'($urandom);
        if (pick < 3)
        begin
            ev.op = OP_NONE;
        end
        else if (pick < 3 + read_w)
        begin
            ev.op = OP_READ;
        end
        else if (pick < 3 + read_w + (97 - read_w) / 2)
        begin
            if ($urandom_range(0, 49) == 0)
                gen_time = TIME_W'($urandom);
            else
                gen_time = gen_time + TIME_W'($urandom_range(0, cfg_period / 4 + 2));
            if ($urandom_range(0, 3) == 0)
                gen_levels = $urandom_range(0, 1) ? '0 : PUSH_LVL_W'($urandom_range(0, 15));
            ev.op   = OP_SCAN;
            ev.now  = gen_time;
            ev.push = gen_levels;
        end
        else
        begin
            ev.op = OP_ROTARY;
            if ($urandom_range(0, 7) != 0)
            begin
                for (int k = 0; k < ROTARY_KEYS; k++)
                begin
                    pins = PINS_NONE;
                    if (knob_active[k])
                    begin
                        pins        = knob_pins(knob_down[k], knob_pos[k]);
                        knob_pos[k] = (knob_pos[k] + 1) % 4;
                        if (knob_pos[k] == 0)
                        begin
                            knob_down[k]   = $urandom_range(0, 1);
                            knob_active[k] = ($urandom_range(0, 3) != 0);
                        end
                    end
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        knob_active[k] = 1'b1;
                    end
                    ev.a[k] = pins[1];
                    ev.b[k] = pins[0];
                end
            end
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver side: random back-pressure.
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare each result taken with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: result with no item waiting: status %0d code %0d level %0d",
                         $time, out_ch.read_status, out_ch.key_code, out_ch.fifo_level);
                mismatches++;
            end
            else
            begin
                arrived = expected_results.pop_front();
                check_field("read_status", int'(arrived.status), int'(out_ch.read_status));
                check_field("key_code", int'(arrived.code), int'(out_ch.key_code));
                check_field("fifo_level", int'(arrived.level), int'(out_ch.fifo_level));
                check_field("push_held", int'(arrived.held), int'(out_ch.push_held));
            end
        end
    end

    // Watchdog on cycles in which no item moves on either channel and no setting is written.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        scan_row_t   dir_rows [$];
        key_event_t  ev;
        key_result_t no_result;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        in_ch.valid           = 1'b0;
        in_ch.opcode          = OP_SCAN;
        in_ch.now_time        = '0;
        in_ch.push_levels     = '0;
        in_ch.rotary_a_levels = '0;
        in_ch.rotary_b_levels = '0;
        out_ch.ready          = 1'b0;
        mismatches            = 0;
        stall_cycles          = 0;
        send_idle_pct         = 30;
        recv_idle_pct         = 55;
        no_result             = '0;

        // Model state after reset.
        cfg_period    = SCAN_PERIOD_RST;
        cfg_push_base = PUSH_BASE_RST;
        cfg_knob_base = ROTARY_BASE_RST;
        cfg_read_en   = 1'b1;
        wr_idx        = '0;
        rd_idx        = '0;
        key_busy      = 1'b0;
        knob_code     = '0;
        for (int i = 0; i < PUSH_KEYS; i++)
        begin
            key_phase[i]    = PP_IDLE;
            key_deadline[i] = '0;
        end
        for (int i = 0; i < ROTARY_KEYS; i++)
        begin
            knob_phase[i]  = RP_IDLE;
            knob_pos[i]    = 0;
            knob_down[i]   = 1'b0;
            knob_active[i] = 1'b1;
        end
        gen_time   = '0;
        gen_levels = '0;

        // Directed table: empty read, unused opcode, arming and sampling, busy blocking,
        // one detent each way, deadline wrap near the top of the time range.
        dir_rows = '{
            mk_row(OP_READ,   0,     4'h0, 0, 0, 1, RS_EMPTY, 0, 0, 0),
            mk_row(OP_NONE,   65535, 4'hF, 3, 3, 1, RS_NONE,  0, 0, 0),
            mk_row(OP_SCAN,   100,   4'hF, 0, 0, 1, RS_NONE,  0, 0, 0),
            mk_row(OP_SCAN,   105,   4'hF, 0, 0, 1, RS_NONE,  0, 0, 0),
            mk_row(OP_SCAN,   106,   4'h5, 0, 0, 1, RS_NONE,  0, 2, 1),
            mk_row(OP_ROTARY, 0,     4'h0, 3, 3, 1, RS_NONE,  0, 2, 1),
            mk_row(OP_SCAN,   107,   4'h1, 0, 0, 1, RS_NONE,  0, 2, 0),
            mk_row(OP_READ,   0,     4'h0, 0, 0, 1, RS_CODE,  0, 1, 0),
            mk_row(OP_READ,   0,     4'h0, 0, 0, 1, RS_CODE,  2, 0, 0),
            mk_row(OP_ROTARY, 0,     4'h0, 1, 0, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_ROTARY, 0,     4'h0, 1, 1, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_ROTARY, 0,     4'h0, 0, 1, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_ROTARY, 0,     4'h0, 0, 0, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_ROTARY, 0,     4'h0, 0, 2, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_ROTARY, 0,     4'h0, 2, 2, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_ROTARY, 0,     4'h0, 2, 0, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_ROTARY, 0,     4'h0, 0, 0, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_READ,   0,     4'h0, 0, 0, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_READ,   0,     4'h0, 0, 0, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_SCAN,   65533, 4'h0, 0, 0, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_SCAN,   65534, 4'h4, 0, 0, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_SCAN,   0,     4'h4, 0, 0, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_READ,   0,     4'h0, 0, 0, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_ROTARY, 0,     4'h0, 2, 1, 0, RS_NONE,  0, 0, 0),
            mk_row(OP_SCAN,   4,     4'h0, 0, 0, 0, RS_NONE,  0, 0, 0)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].res);

        // Random phases; each phase first applies its settings and idling pattern.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            send_idle_pct = (p < 2) ? 30 : (p < 4) ? 55 : 0;
            recv_idle_pct = (p < 2) ? 55 : (p < 4) ? 30 : 0;
            case (p)
                0: apply_settings(8'd6, 8'd0, 8'd8, 1'b1);
                1: apply_settings(8'd0, 8'd255, 8'd255, 1'b1);
                2: apply_settings(8'd255, 8'd128, 8'd0, 1'b0);
                3: apply_settings(8'd1, 8'd254, 8'd254, 1'b1);
                4: apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
                default: apply_settings(8'd6, 8'd0, 8'd8, 1'b1);
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Few reads in the second phase so the FIFO runs full, many in the fourth.
                next_random_event((p == 1) ? 8 : (p == 3) ? 35 : 20, ev);
                send_event(ev, 1'b0, no_result);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
